### hdl/nra_pkg.sv
package nra_pkg;

  // Fixed field widths of the register and index ports
  localparam int CFG_W = 7;
  localparam int IDX_W = 6;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_COORD_BITS  = 26;

  // Operation codes carried on in_op
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

### hdl/nra_ram.sv
module nra_ram #(
  parameter int WIDTH = 104,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nearest_region_assign_top.sv
// Nearest region assign: a table of placement-region rectangles is loaded one
// beat at a time (in_op write, busy stays low), then a query
// beat with a cell point and size returns one result beat on out_strobe: the
// lowest-indexed region containing the point (edges inclusive, inside_res 1),
// else the nearest region by Manhattan distance whose width and height hold the
// cell (ties to the lower index), else placed 0. A query walks the first
// min(cfg_region_count, MAX_REGIONS) entries one per cycle through the single
// read port of the region memory, then drains a two-stage compare pipeline.
// The result beat is shown in the cycle in which busy falls, and a new beat is
// taken in that same cycle. The receiver cannot stall: sample out_region_number,
// out_placed and out_inside_res in the out_strobe cycle.
// Entries are undefined until written; a query must not search one that was
// never written. Write cfg_region_count only while busy is low.
module nearest_region_assign_top #(
  parameter int MAX_REGIONS = nra_pkg::DEF_MAX_REGIONS,
  parameter int COORD_BITS  = nra_pkg::DEF_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_op,
  input  logic [nra_pkg::IDX_W-1:0] in_region_index,
  input  logic [COORD_BITS-1:0]    in_region_x_start,
  input  logic [COORD_BITS-1:0]    in_region_x_end,
  input  logic [COORD_BITS-1:0]    in_region_y_start,
  input  logic [COORD_BITS-1:0]    in_region_y_end,
  input  logic [COORD_BITS-1:0]    in_point_x,
  input  logic [COORD_BITS-1:0]    in_point_y,
  input  logic [COORD_BITS-1:0]    in_cell_width,
  input  logic [COORD_BITS-1:0]    in_cell_height,
  // configuration
  input  logic                     cfg_we,
  input  logic [nra_pkg::CFG_W-1:0] cfg_wdata,
  // result channel
  output logic                     out_strobe,
  output logic [nra_pkg::IDX_W-1:0] out_region_number,
  output logic                     out_placed,
  output logic                     out_inside_res
);

  import nra_pkg::*;

  localparam int ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int LIM_W  = $clog2(MAX_REGIONS + 1);
  localparam int SCAN_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam int ENT_W  = 4 * COORD_BITS;
  localparam int DIST_W = COORD_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] region_count_r;

  // ---------------------------------------------------------------------------
  // Command accept and region memory write
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        wr_en;
  logic [31:0] widx_ext;
  logic [ADDR_W-1:0] waddr;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign widx_ext = 32'(in_region_index);
  assign waddr    = widx_ext[ADDR_W-1:0];
  // drop writes beyond the table
  assign wr_en    = accept && (in_op == OP_WRITE) && (widx_ext < 32'(MAX_REGIONS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
    end else if (cfg_we) begin
      region_count_r <= cfg_wdata;
    end
  end

  // Entry layout: {left, right, bottom, top}
  logic [ENT_W-1:0]  wr_data;
  logic [ENT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_data = {in_region_x_start, in_region_x_end, in_region_y_start, in_region_y_end};

  // Writes happen only while idle and the scan reads only while busy, so the
  // busy flag is the interlock between the two memory ports.
  nra_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_REGIONS),
    .AW    (ADDR_W)
  ) u_region_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Query capture and scan sequencer
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] px_r, py_r, cw_r, ch_r;
  logic [SCAN_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [SCAN_W-1:0]     lim_r, lim_nxt;
  logic [SCAN_W-1:0]     cnt_ext;
  logic                  issue;

  assign cnt_ext = SCAN_W'(region_count_r);
  assign issue   = (state_r == ST_SCAN) && (scan_cnt_r < lim_r);
  assign rd_addr = scan_cnt_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_QUERY)) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
      cw_r <= in_cell_width;
      ch_r <= in_cell_height;
    end
  end

  // Read stage: the memory output belongs to the entry issued last cycle
  logic              rv_r;
  logic [ADDR_W-1:0] ridx_r;

  // Gap/fit stage
  logic              va_r;
  logic [ADDR_W-1:0] aidx_r;
  logic              ain_r;
  logic              afit_r;
  logic [COORD_BITS-1:0] agx_r, agy_r;

  logic [COORD_BITS-1:0] e_l, e_r, e_b, e_t;
  logic                  e_in, e_fit;
  logic [COORD_BITS-1:0] e_gx, e_gy;

  assign {e_l, e_r, e_b, e_t} = rd_data;

  always_comb begin
    e_in  = (px_r >= e_l) && (px_r <= e_r) && (py_r >= e_b) && (py_r <= e_t);
    // an inverted span never holds a cell
    e_fit = (e_t >= e_b) && (ch_r <= e_t - e_b) && (e_r >= e_l) && (cw_r <= e_r - e_l);
    if (px_r < e_l) begin
      e_gx = e_l - px_r;
    end else if (px_r > e_r) begin
      e_gx = px_r - e_r;
    end else begin
      e_gx = '0;
    end
    if (py_r < e_b) begin
      e_gy = e_b - py_r;
    end else if (py_r > e_t) begin
      e_gy = py_r - e_t;
    end else begin
      e_gy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      va_r <= 1'b0;
    end else begin
      rv_r <= issue;
      va_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= rd_addr;
    aidx_r <= ridx_r;
    ain_r  <= e_in;
    afit_r <= e_fit;
    agx_r  <= e_gx;
    agy_r  <= e_gy;
  end

  // ---------------------------------------------------------------------------
  // Selection stage: first inside hit, and nearest fitting region
  // ---------------------------------------------------------------------------
  logic              hit_r, hit_nxt;
  logic [ADDR_W-1:0] hit_idx_r, hit_idx_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [DIST_W-1:0] cand_d;

  assign cand_d = DIST_W'(agx_r) + DIST_W'(agy_r);

  // Result registers
  logic              strobe_r, strobe_nxt;
  logic [IDX_W-1:0]  num_r, num_nxt;
  logic              placed_r, placed_nxt;
  logic              ins_r, ins_nxt;
  logic [31:0]       hit_ext, best_ext;

  assign hit_ext  = 32'(hit_idx_r);
  assign best_ext = 32'(best_idx_r);

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    lim_nxt      = lim_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_d_nxt   = best_d_r;
    strobe_nxt   = 1'b0;
    num_nxt      = num_r;
    placed_nxt   = placed_r;
    ins_nxt      = ins_r;

    // advance the accumulators on every entry leaving the gap stage
    if (va_r) begin
      if (ain_r && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = aidx_r;
      end
      if (afit_r && (!found_r || (cand_d < best_d_r))) begin
        found_nxt    = 1'b1;
        best_idx_nxt = aidx_r;
        best_d_nxt   = cand_d;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_QUERY)) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
          // saturate the count at the table size
          lim_nxt      = (cnt_ext > SCAN_W'(MAX_REGIONS)) ? SCAN_W'(MAX_REGIONS) : cnt_ext;
          hit_nxt      = 1'b0;
          found_nxt    = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + SCAN_W'(1);
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // pipeline empty: accumulators are final, show the result for one cycle
        if (!rv_r && !va_r) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          if (hit_r) begin
            num_nxt    = hit_ext[IDX_W-1:0];
            placed_nxt = 1'b1;
            ins_nxt    = 1'b1;
          end else if (found_r) begin
            num_nxt    = best_ext[IDX_W-1:0];
            placed_nxt = 1'b1;
            ins_nxt    = 1'b0;
          end else begin
            num_nxt    = '0;
            placed_nxt = 1'b0;
            ins_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      hit_r    <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      hit_r    <= hit_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    lim_r      <= lim_nxt;
    hit_idx_r  <= hit_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    num_r      <= num_nxt;
    placed_r   <= placed_nxt;
    ins_r      <= ins_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_region_number = num_r;
  assign out_placed        = placed_r;
  assign out_inside_res    = ins_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wr_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_IDLE))
    else $error("region write while a query is in progress");

  a_strobe_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_nxt |-> (state_r == ST_FLUSH) && !rv_r && !va_r)
    else $error("result shown with entries still in the pipeline");

  a_inside_needs_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_inside_res |-> out_placed)
    else $error("inside result without placement");

  a_read_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> (state_r == ST_SCAN) || (state_r == ST_FLUSH))
    else $error("memory read outstanding outside a query");

  a_one_result_beat: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held longer than one cycle");

endmodule

### dv/tb_nearest_region_assign_top.sv
module tb_nearest_region_assign_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nra_pkg::*;

  localparam int NREG = DEF_MAX_REGIONS;
  localparam int CB = DEF_COORD_BITS;
  // Long enough for a full-table query to drop busy; allow a little more.
  localparam int SETTLE = NREG + 8;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CB-1:0] CMAX = '1;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    logic [IDX_W-1:0] num;
    logic             placed;
    logic             hit;
  } verdict_t;

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] idx;
    coord_t           xs, xe, ys, ye;
    coord_t           px, py, cw, ch;
  } beat_t;

  // One row of the directed list: the beat, an optional region_count to
  // program before it (-1 keeps the current one), and an optional literal
  // expectation that replaces the predicted one.
  typedef struct {
    beat_t    b;
    int       new_count;
    bit       typed;
    verdict_t want;
  } row_t;

  localparam verdict_t UNPLACED = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_op = OP_WRITE;
  logic [IDX_W-1:0]     in_region_index = '0;
  coord_t               in_region_x_start = '0;
  coord_t               in_region_x_end = '0;
  coord_t               in_region_y_start = '0;
  coord_t               in_region_y_end = '0;
  coord_t               in_point_x = '0;
  coord_t               in_point_y = '0;
  coord_t               in_cell_width = '0;
  coord_t               in_cell_height = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 out_strobe;
  logic [IDX_W-1:0]     out_region_number;
  logic                 out_placed;
  logic                 out_inside_res;

  // Shadow copy of the region table and the count register.
  coord_t left_e [NREG];
  coord_t right_e [NREG];
  coord_t bottom_e [NREG];
  coord_t top_e [NREG];
  int     region_count = 0;

  verdict_t pending_verdicts [$];
  row_t     directed_rows [$];

  bit quiet = 1'b0;
  int errors = 0;
  int stall_cycles = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_settings = 0;
  int n_hits = 0;
  int n_near = 0;
  int n_unplaced = 0;

  nearest_region_assign_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_region_index   (in_region_index),
    .in_region_x_start (in_region_x_start),
    .in_region_x_end   (in_region_x_end),
    .in_region_y_start (in_region_y_start),
    .in_region_y_end   (in_region_y_end),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_cell_width     (in_cell_width),
    .in_cell_height    (in_cell_height),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_region_number (out_region_number),
    .out_placed        (out_placed),
    .out_inside_res    (out_inside_res)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic coord_t axis_gap(coord_t p, coord_t lo, coord_t hi);
    if (p < lo) return lo - p;
    if (p > hi) return p - hi;
    return '0;
  endfunction

  // An inverted span never holds anything, not even a zero-size cell.
  function automatic bit span_fits(coord_t lo, coord_t hi, coord_t size);
    return hi >= lo && size <= coord_t'(hi - lo);
  endfunction

  // Containment wins first (lowest index); otherwise the nearest fitting
  // region by Manhattan distance, ties to the lower index.
  function automatic verdict_t assign_region(coord_t px, coord_t py, coord_t cw,
                                             coord_t ch);
    verdict_t    v;
    int          n;
    bit          found;
    logic [CB:0] d;
    logic [CB:0] best;
    v = UNPLACED;
    found = 1'b0;
    best = '0;
    n = (region_count > NREG) ? NREG : region_count;
    for (int i = 0; i < n; i++) begin
      if (px >= left_e[i] && px <= right_e[i] && py >= bottom_e[i] && py <= top_e[i]) begin
        v.num = IDX_W'(i);
        v.placed = 1'b1;
        v.hit = 1'b1;
        return v;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!span_fits(left_e[i], right_e[i], cw) || !span_fits(bottom_e[i], top_e[i], ch))
        continue;
      d = {1'b0, axis_gap(px, left_e[i], right_e[i])} +
          {1'b0, axis_gap(py, bottom_e[i], top_e[i])};
      if (!found || d < best) begin
        found = 1'b1;
        best = d;
        v.num = IDX_W'(i);
      end
    end
    v.placed = found;
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  // Fill every field with random bits; the caller overrides what matters.
  function automatic beat_t noise_beat();
    beat_t b;
    b.op = 1'($urandom);
    b.idx = IDX_W'($urandom);
    b.xs = coord_t'($urandom);
    b.xe = coord_t'($urandom);
    b.ys = coord_t'($urandom);
    b.ye = coord_t'($urandom);
    b.px = coord_t'($urandom);
    b.py = coord_t'($urandom);
    b.cw = coord_t'($urandom);
    b.ch = coord_t'($urandom);
    return b;
  endfunction

  function automatic row_t wr_row(int idx, coord_t xs, coord_t xe, coord_t ys, coord_t ye);
    row_t r;
    r.b = noise_beat();
    r.b.op = OP_WRITE;
    r.b.idx = IDX_W'(idx);
    r.b.xs = xs;
    r.b.xe = xe;
    r.b.ys = ys;
    r.b.ye = ye;
    r.new_count = -1;
    r.typed = 1'b0;
    r.want = UNPLACED;
    return r;
  endfunction

  function automatic row_t q_row(coord_t px, coord_t py, coord_t cw, coord_t ch,
                                 int new_count = -1, bit typed = 1'b0,
                                 verdict_t want = UNPLACED);
    row_t r;
    r.b = noise_beat();
    r.b.op = OP_QUERY;
    r.b.px = px;
    r.b.py = py;
    r.b.cw = cw;
    r.b.ch = ch;
    r.new_count = new_count;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Append one row to the directed list.
  function automatic void add_row(row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // Mostly compact rectangles (near the origin or at a random base, so that
  // overlaps and distance ties are common), some inverted, some full-range,
  // some pinned to the coordinate extremes.
  function automatic beat_t rand_write(int idx);
    beat_t  b;
    int     mode;
    int     bx;
    int     by;
    coord_t t;
    b = noise_beat();
    b.op = OP_WRITE;
    b.idx = IDX_W'(idx);
    mode = $urandom_range(0, 19);
    if (mode < 14) begin
      bx = (mode < 10) ? 0 : $urandom_range(0, int'(CMAX) - 1000);
      by = (mode < 10) ? 0 : $urandom_range(0, int'(CMAX) - 1000);
      b.xs = coord_t'(bx + $urandom_range(0, 400));
      b.xe = coord_t'(b.xs + $urandom_range(0, 80));
      b.ys = coord_t'(by + $urandom_range(0, 400));
      b.ye = coord_t'(b.ys + $urandom_range(0, 80));
      if (mode == 13) begin
        // invert one axis: move the start edge past the end edge
        if ($urandom_range(0, 1)) begin
          t = coord_t'(b.xe + 1 + $urandom_range(0, 40));
          b.xs = t;
        end else begin
          t = coord_t'(b.ye + 1 + $urandom_range(0, 40));
          b.ys = t;
        end
      end
    end else if (mode >= 18) begin
      b.xs = $urandom_range(0, 1) ? CMAX : '0;
      b.xe = $urandom_range(0, 1) ? CMAX : '0;
      b.ys = $urandom_range(0, 1) ? CMAX : '0;
      b.ye = $urandom_range(0, 1) ? CMAX : '0;
    end
    return b;
  endfunction

  // A coordinate around the span [lo, hi] (either order), sometimes on an edge.
  function automatic coord_t near(coord_t lo, coord_t hi);
    longint a;
    longint z;
    longint v;
    a = (lo < hi) ? longint'(lo) : longint'(hi);
    z = (lo < hi) ? longint'(hi) : longint'(lo);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? coord_t'(a) : coord_t'(z);
    v = a - 40 + longint'($urandom_range(0, int'(z - a) + 80));
    if (v < 0) v = 0;
    if (v > longint'(CMAX)) v = longint'(CMAX);
    return coord_t'(v);
  endfunction

  function automatic beat_t rand_query();
    beat_t b;
    int    pick;
    int    n;
    int    k;
    b = noise_beat();
    b.op = OP_QUERY;
    n = (region_count > NREG) ? NREG : region_count;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      k = (n > 0) ? $urandom_range(0, n - 1) : 0;
      b.px = near(left_e[k], right_e[k]);
      b.py = near(bottom_e[k], top_e[k]);
    end else if (pick < 9) begin
      b.px = coord_t'($urandom_range(0, 500));
      b.py = coord_t'($urandom_range(0, 500));
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      b.cw = '0;
      b.ch = '0;
    end else if (pick < 8) begin
      b.cw = coord_t'($urandom_range(0, 60));
      b.ch = coord_t'($urandom_range(0, 60));
    end else if (pick == 8) begin
      b.ch = coord_t'($urandom_range(0, 60));
    end
    return b;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Idle for gap cycles, then hold the beat until the block takes it. Keep
  // start high across back-to-back beats so it gets one assignment per step.
  task automatic send_beat(beat_t b, int gap, bit typed = 1'b0,
                           verdict_t want = UNPLACED);
    verdict_t v;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op <= b.op;
    in_region_index <= b.idx;
    in_region_x_start <= b.xs;
    in_region_x_end <= b.xe;
    in_region_y_start <= b.ys;
    in_region_y_end <= b.ye;
    in_point_x <= b.px;
    in_point_y <= b.py;
    in_cell_width <= b.cw;
    in_cell_height <= b.ch;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Beat accepted at this edge: advance the shadow state.
    if (b.op == OP_WRITE) begin
      left_e[b.idx] = b.xs;
      right_e[b.idx] = b.xe;
      bottom_e[b.idx] = b.ys;
      top_e[b.idx] = b.ye;
      n_writes++;
    end else begin
      v = typed ? want : assign_region(b.px, b.py, b.cw, b.ch);
      pending_verdicts = {pending_verdicts, v};
      n_queries++;
    end
  endtask

  // Drain every outstanding result, let the block settle, then write the
  // count register while it is idle.
  task automatic program_count(int value);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    region_count = value;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the strobe lasts one cycle and cannot be held off, so
  // sample it at every edge and match against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;
    if (rst_n && out_strobe) begin
      seen = {out_region_number, out_placed, out_inside_res};
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: region %0d placed %0b inside %0b",
                 $time, seen.num, seen.placed, seen.hit);
      end else begin
        want = pending_verdicts.pop_front();
        if (seen !== want) begin
          errors++;
          $display({"%0t: mismatch: expected region %0d placed %0b inside %0b, ",
                    "got region %0d placed %0b inside %0b"},
                   $time, want.num, want.placed, want.hit, seen.num, seen.placed,
                   seen.hit);
        end
        if (want.hit) n_hits++;
        else if (want.placed) n_near++;
        else n_unplaced++;
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no beat moved for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    row_t row;
    int   settings_seq [11];

    for (int i = 0; i < NREG; i++) begin
      left_e[i] = '0;
      right_e[i] = '0;
      bottom_e[i] = '0;
      top_e[i] = '0;
    end

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed list. Count is zero out of reset, so nothing is searched.
    add_row(q_row('0, '0, '0, '0, -1, 1'b1, UNPLACED));
    add_row(q_row(CMAX, CMAX, CMAX, CMAX, -1, 1'b1, UNPLACED));
    // Load four entries: a square, a wide box, an x-inverted strip, a corner.
    add_row(wr_row(0, 10, 20, 10, 20));
    add_row(wr_row(1, 100, 199, 0, 49));
    add_row(wr_row(2, 50, 40, '0, CMAX));
    add_row(wr_row(3, CMAX, CMAX, CMAX, CMAX));
    // Point inside, then point on the corner edges (inclusive).
    add_row(q_row(15, 15, 0, 0, 3, 1'b1, verdict_t'{6'd0, 1'b1, 1'b1}));
    add_row(q_row(10, 20, 5, 5, -1, 1'b1, verdict_t'{6'd0, 1'b1, 1'b1}));
    // Zero-size cell outside everything; the inverted strip never fits.
    add_row(q_row(0, 0, 0, 0));
    add_row(q_row(45, 5, 0, 0));
    // Cell too wide for the square, then too wide for anything.
    add_row(q_row(45, 5, 11, 0));
    add_row(q_row(45, 5, 100, 0));
    // Equal distance to the square and the wide box: lower index wins.
    add_row(q_row(60, 15, 0, 0));
    // Open up the corner entry; top coordinate lands inside it.
    add_row(q_row(CMAX, CMAX, 0, 0, 4, 1'b1, verdict_t'{6'd3, 1'b1, 1'b1}));
    add_row(q_row(CMAX, coord_t'(CMAX - 1), 0, 0));
    add_row(q_row('0, '0, CMAX, CMAX, -1, 1'b1, UNPLACED));
    // Overwrite entry 0 with a full-width line and hit it both ways.
    add_row(wr_row(0, '0, CMAX, '0, '0));
    add_row(q_row(7, 3, CMAX, 0));
    add_row(q_row(20, 0, 0, 0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.new_count >= 0) program_count(row.new_count);
      send_beat(row.b, draw_gap(), row.typed, row.want);
    end

    // Fill the whole table before any count can reach past entry 3.
    for (int k = 0; k < NREG; k++) begin
      send_beat(rand_write(k), draw_gap());
      if (k % 2) send_beat(rand_query(), draw_gap());
    end

    // Sweep count settings: single entry, full table, saturating values,
    // zero, and a few in between. Every third phase runs without gaps.
    settings_seq = '{1, NREG, 127, NREG + 1, 2, 0, $urandom_range(3, NREG - 1),
                     NREG, 100, NREG - 1, 8};
    foreach (settings_seq[p]) begin
      program_count(settings_seq[p]);
      quiet = (p % 3 == 0);
      repeat (112) begin
        if ($urandom_range(0, 99) < 25) begin
          send_beat(rand_write($urandom_range(0, NREG - 1)), draw_gap());
        end else begin
          send_beat(rand_query(), draw_gap());
        end
      end
    end

    // Drop start, drain outstanding results, then allow one query's latency.
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d region writes and %0d queries over %0d count settings (0 to 127).",
             n_writes, n_queries, n_settings);
    $display("Results: %0d inside hits, %0d nearest placements, %0d unplaced, %0d errors.",
             n_hits, n_near, n_unplaced, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
